[rtl/gdb_pkg.sv]
// Shared widths, status codes, calendar helpers and controller/datapath bundles.
`timescale 1ns / 1ps

package gdb_pkg;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int COUNT_W  = 22;
  localparam int STATUS_W = 3;

  localparam int unsigned MAX_YEAR_DEF = 9999;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  localparam logic [DAY_W-1:0] FIRST_DAY = DAY_W'(1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Divisibility by 25 through a scaled reciprocal: ceil(2^19 / 25).
  localparam int          DIV25_SHIFT = 19;
  localparam logic [14:0] DIV25_MUL   = 15'd20972;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_START_MONTH = 3'd1;
  localparam logic [STATUS_W-1:0] ST_START_DAY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_END_MONTH   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_END_DAY     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ORDER       = 3'd5;

  typedef enum logic [1:0] {
    CHK_OK    = 2'd0,
    CHK_MONTH = 2'd1,
    CHK_DAY   = 2'd2
  } chk_t;

  typedef enum logic [1:0] {
    LEAP_START = 2'd0,
    LEAP_END   = 2'd1,
    LEAP_WALK  = 2'd2
  } leap_sel_t;

  typedef struct packed {
    logic                load;
    leap_sel_t           leap_sel;
    logic                walk_init;
    logic                walk_step;
    logic                result_load;
    logic [STATUS_W-1:0] result_code;
  } cmd_t;

  typedef struct packed {
    chk_t start_code;
    chk_t end_code;
    logic end_before;
    logic at_end;
    logic year_roll;
  } sts_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (m == MONTH_FEB) begin
      len = leap ? DAY_W'(29) : DAY_W'(28);
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = DAY_W'(30);
    end else begin
      len = DAY_W'(31);
    end
    return len;
  endfunction

  function automatic chk_t check_date(input logic [DAY_W-1:0] d,
                                      input logic [MONTH_W-1:0] m,
                                      input logic leap);
    chk_t code;
    if (m < MONTH_JAN || m > MONTH_DEC) begin
      code = CHK_MONTH;
    end else if (d < FIRST_DAY || d > month_len(m, leap)) begin
      code = CHK_DAY;
    end else begin
      code = CHK_OK;
    end
    return code;
  endfunction

endpackage

[rtl/gdb_in_if.sv]
// Input channel: a start date and an end date with valid/ready handshake.
`timescale 1ns / 1ps

interface gdb_in_if;
  logic                        valid;
  logic                        ready;
  logic [gdb_pkg::DAY_W-1:0]   start_day;
  logic [gdb_pkg::MONTH_W-1:0] start_month;
  logic [gdb_pkg::YEAR_W-1:0]  start_year;
  logic [gdb_pkg::DAY_W-1:0]   end_day;
  logic [gdb_pkg::MONTH_W-1:0] end_month;
  logic [gdb_pkg::YEAR_W-1:0]  end_year;

  modport source (
    output valid, start_day, start_month, start_year, end_day, end_month, end_year,
    input  ready
  );
  modport sink (
    input  valid, start_day, start_month, start_year, end_day, end_month, end_year,
    output ready
  );
endinterface

[rtl/gdb_out_if.sv]
// Output channel: day count and status with valid/ready handshake.
`timescale 1ns / 1ps

interface gdb_out_if;
  logic                         valid;
  logic                         ready;
  logic [gdb_pkg::COUNT_W-1:0]  day_count;
  logic [gdb_pkg::STATUS_W-1:0] status;

  modport source (
    output valid, day_count, status,
    input  ready
  );
  modport sink (
    input  valid, day_count, status,
    output ready
  );
endinterface

[rtl/gdb_dp.sv]
// Datapath: captured dates, shared leap-year unit, day walker and result register.
`timescale 1ns / 1ps

module gdb_dp #(
  parameter int unsigned MAX_YEAR = gdb_pkg::MAX_YEAR_DEF
) (
  input  logic                         clk,
  input  logic [gdb_pkg::DAY_W-1:0]    start_day,
  input  logic [gdb_pkg::MONTH_W-1:0]  start_month,
  input  logic [gdb_pkg::YEAR_W-1:0]   start_year,
  input  logic [gdb_pkg::DAY_W-1:0]    end_day,
  input  logic [gdb_pkg::MONTH_W-1:0]  end_month,
  input  logic [gdb_pkg::YEAR_W-1:0]   end_year,
  input  gdb_pkg::cmd_t                cmd,
  output gdb_pkg::sts_t                sts,
  output logic [gdb_pkg::COUNT_W-1:0]  day_count,
  output logic [gdb_pkg::STATUS_W-1:0] status
);

  logic [gdb_pkg::DAY_W-1:0]   sd, ed, walk_day;
  logic [gdb_pkg::MONTH_W-1:0] sm, em, walk_month;
  logic [gdb_pkg::YEAR_W-1:0]  sy, ey, walk_year;
  logic [gdb_pkg::COUNT_W-1:0] day_counter;
  logic                        leap_q;

  logic [gdb_pkg::YEAR_W-1:0]  sy_clamp, ey_clamp, leap_year_in;
  logic [gdb_pkg::YEAR_W+14:0] div25_prod;
  logic                        div25, leap_next;
  logic [gdb_pkg::DAY_W-1:0]   walk_len;

  // Years above the bound are taken as the bound itself.
  assign sy_clamp = (32'(start_year) > MAX_YEAR) ? gdb_pkg::YEAR_W'(MAX_YEAR) : start_year;
  assign ey_clamp = (32'(end_year) > MAX_YEAR) ? gdb_pkg::YEAR_W'(MAX_YEAR) : end_year;

  always_comb begin
    unique case (cmd.leap_sel)
      gdb_pkg::LEAP_START: leap_year_in = sy;
      gdb_pkg::LEAP_END:   leap_year_in = ey;
      gdb_pkg::LEAP_WALK:  leap_year_in = walk_year;
      default:             leap_year_in = walk_year;
    endcase
  end

  // A year is divisible by 25 exactly when the low fraction bits of y * ceil(2^19/25)
  // stay below the multiplier; a century year is a leap year only when also divisible by 16.
  assign div25_prod = (gdb_pkg::YEAR_W + 15)'(leap_year_in) *
                      (gdb_pkg::YEAR_W + 15)'(gdb_pkg::DIV25_MUL);
  assign div25 = div25_prod[gdb_pkg::DIV25_SHIFT-1:0] <
                 gdb_pkg::DIV25_SHIFT'(gdb_pkg::DIV25_MUL);
  assign leap_next = (leap_year_in[1:0] == 2'b00) && (!div25 || leap_year_in[3:0] == 4'b0000);

  assign walk_len = gdb_pkg::month_len(walk_month, leap_q);

  always_comb begin
    sts.start_code = gdb_pkg::check_date(sd, sm, leap_q);
    sts.end_code   = gdb_pkg::check_date(ed, em, leap_q);
    sts.end_before = {ey, em, ed} < {sy, sm, sd};
    sts.at_end     = (walk_day == ed) && (walk_month == em) && (walk_year == ey);
    sts.year_roll  = (walk_day == walk_len) && (walk_month == gdb_pkg::MONTH_DEC);
  end

  always_ff @(posedge clk) begin
    leap_q <= leap_next;
    if (cmd.load) begin
      sd <= start_day;
      sm <= start_month;
      sy <= sy_clamp;
      ed <= end_day;
      em <= end_month;
      ey <= ey_clamp;
    end
    if (cmd.result_load) begin
      status    <= cmd.result_code;
      day_count <= (cmd.result_code == gdb_pkg::ST_OK) ? day_counter : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      walk_day    <= sd;
      walk_month  <= sm;
      walk_year   <= sy;
      day_counter <= '0;
    end else if (cmd.walk_step) begin
      if (walk_day == walk_len) begin
        walk_day <= gdb_pkg::FIRST_DAY;
        if (walk_month == gdb_pkg::MONTH_DEC) begin
          walk_month <= gdb_pkg::MONTH_JAN;
          walk_year  <= walk_year + gdb_pkg::YEAR_W'(1);
        end else begin
          walk_month <= walk_month + gdb_pkg::MONTH_W'(1);
        end
      end else begin
        walk_day <= walk_day + gdb_pkg::DAY_W'(1);
      end
      if (day_counter != gdb_pkg::COUNT_MAX) begin
        day_counter <= day_counter + gdb_pkg::COUNT_W'(1);
      end
    end
  end

endmodule

[rtl/gdb_ctrl.sv]
// Controller: sequences date checks, the day walk and the result handoff.
`timescale 1ns / 1ps

module gdb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output gdb_pkg::cmd_t cmd,
  input  gdb_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAP_S,
    S_CHK_S,
    S_CHK_E,
    S_WALK,
    S_WLEAP,
    S_FIN
  } state_t;

  state_t                       state;
  logic [gdb_pkg::STATUS_W-1:0] code;
  logic                         slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    cmd.load        = (state == S_IDLE) && in_valid;
    cmd.walk_init   = (state == S_CHK_E) && (sts.end_code == gdb_pkg::CHK_OK) &&
                      !sts.end_before;
    cmd.walk_step   = (state == S_WALK) && !sts.at_end;
    cmd.result_load = (state == S_FIN) && slot_free;
    cmd.result_code = code;
    // The leap flag registered in one state serves the check of the next one.
    unique case (state)
      S_LEAP_S: cmd.leap_sel = gdb_pkg::LEAP_START;
      S_CHK_S:  cmd.leap_sel = gdb_pkg::LEAP_END;
      S_CHK_E:  cmd.leap_sel = gdb_pkg::LEAP_START;
      default:  cmd.leap_sel = gdb_pkg::LEAP_WALK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      code      <= gdb_pkg::ST_OK;
    end else begin
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_LEAP_S;
        end
        S_LEAP_S: state <= S_CHK_S;
        S_CHK_S: begin
          priority if (sts.start_code == gdb_pkg::CHK_MONTH) begin
            code  <= gdb_pkg::ST_START_MONTH;
            state <= S_FIN;
          end else if (sts.start_code == gdb_pkg::CHK_DAY) begin
            code  <= gdb_pkg::ST_START_DAY;
            state <= S_FIN;
          end else begin
            state <= S_CHK_E;
          end
        end
        S_CHK_E: begin
          priority if (sts.end_code == gdb_pkg::CHK_MONTH) begin
            code  <= gdb_pkg::ST_END_MONTH;
            state <= S_FIN;
          end else if (sts.end_code == gdb_pkg::CHK_DAY) begin
            code  <= gdb_pkg::ST_END_DAY;
            state <= S_FIN;
          end else if (sts.end_before) begin
            code  <= gdb_pkg::ST_ORDER;
            state <= S_FIN;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          priority if (sts.at_end) begin
            code  <= gdb_pkg::ST_OK;
            state <= S_FIN;
          end else if (sts.year_roll) begin
            state <= S_WLEAP;
          end else begin
            state <= S_WALK;
          end
        end
        S_WLEAP: state <= S_WALK;
        S_FIN: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/gregorian_days_between_dates.sv]
// A bad start date is reported after the leap-year and start-date check states; a bad end date or
// a reversed order after the end-date check state as well. A good item is walked day by day: the
// walker steps one day per cycle and, at each new year, passes through a state that updates the
// shared leap-year unit.
// One item is in work at a time; the next is accepted once the result is in the output register.
// Reset (synchronous, active high) returns the controller to idle and drops the output valid.
`timescale 1ns / 1ps

module gregorian_days_between_dates #(
  parameter int unsigned MAX_YEAR = gdb_pkg::MAX_YEAR_DEF
) (
  input logic      clk,
  input logic      rst,
  gdb_in_if.sink   dates,
  gdb_out_if.source result
);

  gdb_pkg::cmd_t cmd;
  gdb_pkg::sts_t sts;

  gdb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dates.valid),
    .in_ready  (dates.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  gdb_dp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk         (clk),
    .start_day   (dates.start_day),
    .start_month (dates.start_month),
    .start_year  (dates.start_year),
    .end_day     (dates.end_day),
    .end_month   (dates.end_month),
    .end_year    (dates.end_year),
    .cmd         (cmd),
    .sts         (sts),
    .day_count   (result.day_count),
    .status      (result.status)
  );

`ifndef SYNTHESIS
  a_err_zero_count: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != gdb_pkg::ST_OK) |-> (result.day_count == '0))
    else $error("error result carries a nonzero day count");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.status <= gdb_pkg::ST_ORDER))
    else $error("result status outside the defined codes");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (dates.valid && dates.ready) |=> !dates.ready)
    else $error("a second item was taken while one is in work");

  a_walk_not_at_end: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_init |=> !cmd.result_load)
    else $error("result loaded right after the walker was set up");
`endif

endmodule

[test/tb_gregorian_days_between_dates.sv]
// Testbench for gregorian_days_between_dates: queued date pairs, randomized flow, day-count checks.
`timescale 1ns / 1ps

module tb_gregorian_days_between_dates;

  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int RANDOM_PAIRS = 560;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [gdb_pkg::DAY_W-1:0]   sd;
    logic [gdb_pkg::MONTH_W-1:0] sm;
    logic [gdb_pkg::YEAR_W-1:0]  sy;
    logic [gdb_pkg::DAY_W-1:0]   ed;
    logic [gdb_pkg::MONTH_W-1:0] em;
    logic [gdb_pkg::YEAR_W-1:0]  ey;
    bit                          drain;
  } date_pair_t;

  typedef struct {
    logic [gdb_pkg::COUNT_W-1:0]  days;
    logic [gdb_pkg::STATUS_W-1:0] status;
  } span_t;

  logic clk;
  logic rst;

  gdb_in_if  dates ();
  gdb_out_if result ();

  gregorian_days_between_dates u_dut (
    .clk    (clk),
    .rst    (rst),
    .dates  (dates),
    .result (result)
  );

  date_pair_t pairs_pending[$];
  span_t      spans_expected[$];

  int pairs_offered = 0;
  int pairs_taken   = 0;
  int cycles        = 0;
  int errors        = 0;
  int in_gap        = 0;
  int out_stall     = 0;
  int calm_cycles   = 0;

  function automatic bit leap_year_of(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in(int unsigned m, int unsigned y);
    case (m)
      gdb_pkg::MONTH_FEB: return leap_year_of(y) ? 29 : 28;
      gdb_pkg::MONTH_APR, gdb_pkg::MONTH_JUN,
      gdb_pkg::MONTH_SEP, gdb_pkg::MONTH_NOV: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic int unsigned capped_year(int unsigned y);
    return (y > gdb_pkg::MAX_YEAR_DEF) ? gdb_pkg::MAX_YEAR_DEF : y;
  endfunction

  function automatic gdb_pkg::chk_t date_fault(int unsigned d, int unsigned m, int unsigned y);
    if (m < gdb_pkg::MONTH_JAN || m > gdb_pkg::MONTH_DEC) return gdb_pkg::CHK_MONTH;
    if (d < 1 || d > days_in(m, y)) return gdb_pkg::CHK_DAY;
    return gdb_pkg::CHK_OK;
  endfunction

  // Days from the first of January of year 0 up to a legal date.
  function automatic int unsigned day_index(int unsigned d, int unsigned m, int unsigned y);
    int unsigned n;
    n = y * 365;
    if (y > 0) n += (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1;
    for (int unsigned k = 1; k < m; k++) n += days_in(k, y);
    return n + d - 1;
  endfunction

  function automatic span_t span_of_dates(
    logic [gdb_pkg::DAY_W-1:0] sd, logic [gdb_pkg::MONTH_W-1:0] sm,
    logic [gdb_pkg::YEAR_W-1:0] sy_raw,
    logic [gdb_pkg::DAY_W-1:0] ed, logic [gdb_pkg::MONTH_W-1:0] em,
    logic [gdb_pkg::YEAR_W-1:0] ey_raw
  );
    int unsigned   sy;
    int unsigned   ey;
    int unsigned   a;
    int unsigned   b;
    gdb_pkg::chk_t fs;
    gdb_pkg::chk_t fe;
    span_t         s;
    sy = capped_year(sy_raw);
    ey = capped_year(ey_raw);
    s.days = '0;
    s.status = gdb_pkg::ST_OK;
    fs = date_fault(sd, sm, sy);
    fe = date_fault(ed, em, ey);
    if (fs == gdb_pkg::CHK_MONTH) begin
      s.status = gdb_pkg::ST_START_MONTH;
    end else if (fs == gdb_pkg::CHK_DAY) begin
      s.status = gdb_pkg::ST_START_DAY;
    end else if (fe == gdb_pkg::CHK_MONTH) begin
      s.status = gdb_pkg::ST_END_MONTH;
    end else if (fe == gdb_pkg::CHK_DAY) begin
      s.status = gdb_pkg::ST_END_DAY;
    end else begin
      a = day_index(sd, sm, sy);
      b = day_index(ed, em, ey);
      if (b < a) begin
        s.status = gdb_pkg::ST_ORDER;
      end else begin
        s.days = (b - a > gdb_pkg::COUNT_MAX) ? gdb_pkg::COUNT_MAX :
                 gdb_pkg::COUNT_W'(b - a);
      end
    end
    return s;
  endfunction

  // Mostly no pause, often a short one, now and then a long one.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 12);
  endfunction

  task automatic queue_pair(input int sd, input int sm, input int sy,
                            input int ed, input int em, input int ey, input bit drain);
    date_pair_t p;
    p.sd = gdb_pkg::DAY_W'(sd);
    p.sm = gdb_pkg::MONTH_W'(sm);
    p.sy = gdb_pkg::YEAR_W'(sy);
    p.ed = gdb_pkg::DAY_W'(ed);
    p.em = gdb_pkg::MONTH_W'(em);
    p.ey = gdb_pkg::YEAR_W'(ey);
    p.drain = drain;
    pairs_pending.push_back(p);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender: holds an item until it is taken, then waits out its gap.
  always @(negedge clk) begin
    date_pair_t p;
    logic       drive;
    if (rst) begin
      dates.valid <= 1'b0;
    end else if (!dates.valid || pairs_taken == pairs_offered) begin
      drive = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pairs_pending.size() != 0 &&
                   !(pairs_pending[0].drain && spans_expected.size() != 0)) begin
        p = pairs_pending.pop_front();
        dates.start_day   <= p.sd;
        dates.start_month <= p.sm;
        dates.start_year  <= p.sy;
        dates.end_day     <= p.ed;
        dates.end_month   <= p.em;
        dates.end_year    <= p.ey;
        pairs_offered++;
        drive = 1'b1;
        in_gap = (calm_cycles > 0) ? 0 : pick_pause();
      end
      dates.valid <= drive;
    end
  end

  // Receiver: stalls independently of the result valid.
  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (out_stall > 0) begin
      result.ready <= 1'b0;
      out_stall--;
    end else begin
      result.ready <= 1'b1;
      if (calm_cycles == 0 && $urandom_range(3) == 0) out_stall = pick_pause();
    end
  end

  always @(posedge clk) begin
    span_t want;
    if (!rst) begin
      cycles++;
      if (calm_cycles > 0) begin
        calm_cycles--;
      end else if ($urandom_range(299) == 0) begin
        calm_cycles = $urandom_range(400, 100);
      end
      if (result.valid && result.ready) begin
        if (spans_expected.size() == 0) begin
          $error("unexpected result item: day_count %0d status %0d",
                 result.day_count, result.status);
          errors++;
        end else begin
          want = spans_expected.pop_front();
          if (result.day_count !== want.days) begin
            $error("day_count mismatch: expected %0d, got %0d", want.days, result.day_count);
            errors++;
          end
          if (result.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, result.status);
            errors++;
          end
        end
      end
      if (dates.valid && dates.ready) begin
        pairs_taken++;
        want = span_of_dates(dates.start_day, dates.start_month, dates.start_year,
                             dates.end_day, dates.end_month, dates.end_year);
        spans_expected.push_back(want);
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int i;
    int kind;
    int off;
    int sd;
    int sm;
    int sy;
    int ed;
    int em;
    int ey;
    rst = 1'b1;
    dates.valid       = 1'b0;
    dates.start_day   = '0;
    dates.start_month = '0;
    dates.start_year  = '0;
    dates.end_day     = '0;
    dates.end_month   = '0;
    dates.end_year    = '0;
    result.ready      = 1'b0;

    // Leap rules, year and month rollover, bounds of the year range.
    queue_pair( 1,  1,  2000,  1,  1,  2000, 0);
    queue_pair(28,  2,  2000,  1,  3,  2000, 0);
    queue_pair(28,  2,  1900,  1,  3,  1900, 0);
    queue_pair(28,  2,  2024,  1,  3,  2024, 0);
    queue_pair(29,  2,  2000, 28,  2,  2001, 0);
    queue_pair(31, 12,  1999,  1,  1,  2000, 0);
    queue_pair( 1,  1,     0, 31, 12,     0, 0);
    queue_pair(31, 12,     0,  1,  1,     1, 0);
    queue_pair( 1,  1,  9999, 31, 12,  9999, 0);
    // Years above the bound are saturated before the checks, so 12000 is not leap here.
    queue_pair(31, 12, 16383, 31, 12,  9999, 0);
    queue_pair(29,  2, 12000,  1,  3, 12000, 0);
    // Each check in its turn; the first one to fail wins.
    queue_pair(29,  2,  1900,  1,  3,  1900, 0);
    queue_pair( 1,  0,  2000,  1,  1,  2001, 0);
    queue_pair( 1, 15,  2000,  1,  1,  2001, 0);
    queue_pair( 0,  1,  2000,  1,  1,  2001, 0);
    queue_pair(31,  4,  2000,  1,  1,  2001, 0);
    queue_pair( 1,  1,  2000,  1,  0,  2001, 0);
    queue_pair( 1,  1,  2000,  1, 13,  2001, 0);
    queue_pair( 1,  1,  2000,  0,  1,  2001, 0);
    queue_pair( 1,  1,  2000, 31, 11,  2001, 0);
    queue_pair( 2,  1,  2000,  1,  1,  2000, 0);
    queue_pair( 1,  1,  2001, 31, 12,  2000, 0);
    queue_pair(31,  4,  2000,  1,  0,  2000, 0);
    queue_pair( 1, 14,  2000,  0,  0,     0, 0);
    // One long walk across several century years, sent once the block has drained.
    queue_pair( 1,  1,  1601,  1,  1,  2401, 1);

    for (i = 0; i < RANDOM_PAIRS; i++) begin
      kind = $urandom_range(99);
      sy = ($urandom_range(9) < 2) ? $urandom_range(99) * 100 : $urandom_range(16383);
      off = $urandom_range(9);
      off = (off < 6) ? 0 : (off < 9) ? 1 : 2;
      ey = (sy + off > 16383) ? sy : sy + off;
      if (kind < 75) begin
        // Two legal dates a short span apart; some land in reverse order.
        sm = $urandom_range(12, 1);
        sd = $urandom_range(days_in(sm, capped_year(sy)), 1);
        if (kind < 8) begin
          ed = sd;
          em = sm;
          ey = sy;
        end else begin
          em = $urandom_range(12, 1);
          ed = $urandom_range(days_in(em, capped_year(ey)), 1);
        end
      end else begin
        sd = $urandom_range(31);
        sm = $urandom_range(15);
        ed = $urandom_range(31);
        em = $urandom_range(15);
        if (kind >= 90) begin
          // Far-apart years only with a bad start month, so no long walk follows.
          ey = $urandom_range(16383);
          sm = $urandom_range(1) ? 0 : $urandom_range(15, 13);
        end else if ($urandom_range(1) && sy >= off) begin
          ey = sy - off;
        end
      end
      queue_pair(sd, sm, sy, ed, em, ey, (i % 140) == 139);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pairs_pending.size() != 0 || pairs_taken != pairs_offered ||
           spans_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/gdb_pkg.sv
rtl/gdb_in_if.sv
rtl/gdb_out_if.sv
rtl/gdb_dp.sv
rtl/gdb_ctrl.sv
rtl/gregorian_days_between_dates.sv
test/tb_gregorian_days_between_dates.sv
